### sv/compressor_short_cycle_guard_defines.svh
// assertion macros for the compressor short-cycle guard
// expects clk and rst in the scope of each use
`ifndef COMPRESSOR_SHORT_CYCLE_GUARD_DEFINES_SVH
`define COMPRESSOR_SHORT_CYCLE_GUARD_DEFINES_SVH

// same-cycle implication
`define CSCG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CSCG_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/cscg_pkg.sv
// shared types, constants and the evaluate and begin_thaw rules of the short-cycle guard
// no dependencies
package cscg_pkg;

  localparam int CFG_WIDTH      = 16;
  localparam int APB_DATA_WIDTH = 32;
  localparam int APB_ADDR_WIDTH = 4;
  localparam int TICK_MS        = 1000;

  localparam logic [CFG_WIDTH-1:0] RUN_RESET    = CFG_WIDTH'(180000 / TICK_MS);
  localparam logic [CFG_WIDTH-1:0] OFF_RESET    = CFG_WIDTH'(300000 / TICK_MS);
  localparam logic [CFG_WIDTH-1:0] FREEZE_RESET = CFG_WIDTH'(3600000 / TICK_MS);

  localparam logic [1:0] REG_MIN_RUN      = 2'd0;
  localparam logic [1:0] REG_MIN_OFF      = 2'd1;
  localparam logic [1:0] REG_FREEZE_DELAY = 2'd2;

  typedef enum logic [2:0] {
    PH_BOOT   = 3'd0,
    PH_IDLE   = 3'd1,
    PH_COOL   = 3'd2,
    PH_START  = 3'd3,
    PH_REST   = 3'd4,
    PH_FDELAY = 3'd5,
    PH_THAW   = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    TC_HOLD,
    TC_DEC,
    TC_LOAD_RUN,
    TC_LOAD_OFF,
    TC_LOAD_FRZ
  } tc_op_t;

  typedef struct packed {
    phase_t phase;
    logic   call_at_freeze;
    logic   compressor;
    logic   fan;
    logic   led;
  } ctrl_t;

  typedef struct packed {
    ctrl_t  ctrl;
    tc_op_t op;
  } upd_t;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] min_run;
    logic [CFG_WIDTH-1:0] min_off;
    logic [CFG_WIDTH-1:0] freeze_delay;
  } cfg_t;

  function automatic upd_t evaluate(ctrl_t cur, logic mode, logic cool, logic freeze,
                                    logic fd_nonzero);
    upd_t u;
    u.ctrl = cur;
    u.op   = TC_HOLD;
    if (freeze) begin
      u.ctrl.call_at_freeze = cool;
      if (cool && fd_nonzero) begin
        u.op         = TC_LOAD_FRZ;
        u.ctrl.phase = PH_FDELAY;
        u.ctrl.led   = 1'b1;
      end else begin
        u.ctrl.phase      = PH_THAW;
        u.ctrl.compressor = 1'b0;
        u.ctrl.fan        = 1'b1;
        u.ctrl.led        = 1'b1;
      end
    end else if (cool == mode) begin
      u.ctrl.phase      = mode ? PH_COOL : PH_IDLE;
      u.ctrl.compressor = mode;
      u.ctrl.fan        = mode;
      u.ctrl.led        = 1'b0;
    end else if (cool) begin
      u.op              = TC_LOAD_RUN;
      u.ctrl.phase      = PH_START;
      u.ctrl.compressor = 1'b1;
      u.ctrl.fan        = 1'b1;
      u.ctrl.led        = 1'b1;
    end else begin
      u.op              = TC_LOAD_OFF;
      u.ctrl.phase      = PH_REST;
      u.ctrl.compressor = 1'b0;
      u.ctrl.fan        = 1'b1;
      u.ctrl.led        = 1'b1;
    end
    return u;
  endfunction

  function automatic upd_t begin_thaw(ctrl_t cur, logic cool, logic freeze,
                                      logic fd_nonzero);
    upd_t u;
    if (freeze) begin
      u.ctrl            = cur;
      u.op              = TC_HOLD;
      u.ctrl.phase      = PH_THAW;
      u.ctrl.compressor = 1'b0;
      u.ctrl.fan        = 1'b1;
      u.ctrl.led        = 1'b1;
    end else begin
      u = evaluate(cur, 1'b0, cool, 1'b0, fd_nonzero);
    end
    return u;
  endfunction

endpackage

### sv/cscg_ifs.sv
// valid/ready channel interfaces for tick beats and result beats
// no dependencies
interface cscg_tick_if;
  logic valid;
  logic ready;
  logic cool_request;
  logic freeze_alarm;
  modport source(output valid, cool_request, freeze_alarm, input ready);
  modport sink(input valid, cool_request, freeze_alarm, output ready);
endinterface

interface cscg_result_if;
  logic       valid;
  logic       ready;
  logic       compressor_on;
  logic       fan_on;
  logic       busy_led;
  logic [2:0] phase;
  modport source(output valid, compressor_on, fan_on, busy_led, phase, input ready);
  modport sink(input valid, compressor_on, fan_on, busy_led, phase, output ready);
endinterface

### sv/cscg_regs.sv
// apb configuration registers: min run, min off, freeze delay
// depends on cscg_pkg
module cscg_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [cscg_pkg::APB_ADDR_WIDTH-1:0]  paddr,
  input  logic [cscg_pkg::APB_DATA_WIDTH-1:0]  pwdata,
  output logic [cscg_pkg::APB_DATA_WIDTH-1:0]  prdata,
  output logic                                 pready,
  output cscg_pkg::cfg_t                       cfg
);
  import cscg_pkg::*;

  logic [1:0] idx;
  logic       wr_en;

  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_run      <= RUN_RESET;
      cfg.min_off      <= OFF_RESET;
      cfg.freeze_delay <= FREEZE_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_MIN_RUN:      cfg.min_run      <= pwdata[CFG_WIDTH-1:0];
        REG_MIN_OFF:      cfg.min_off      <= pwdata[CFG_WIDTH-1:0];
        REG_FREEZE_DELAY: cfg.freeze_delay <= pwdata[CFG_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MIN_RUN:      prdata = APB_DATA_WIDTH'(cfg.min_run);
      REG_MIN_OFF:      prdata = APB_DATA_WIDTH'(cfg.min_off);
      REG_FREEZE_DELAY: prdata = APB_DATA_WIDTH'(cfg.freeze_delay);
      default:          prdata = '0;
    endcase
  end

endmodule

### sv/cscg_step.sv
// next-state logic for one tick: phase, drive, freeze latch and tick counter
// depends on cscg_pkg
module cscg_step #(
  parameter int COUNT_WIDTH = 16
) (
  input  cscg_pkg::cfg_t          cfg,
  input  cscg_pkg::ctrl_t         cur,
  input  logic [COUNT_WIDTH-1:0]  tick_count,
  input  logic                    cool,
  input  logic                    freeze,
  output cscg_pkg::ctrl_t         ctrl_next,
  output logic [COUNT_WIDTH-1:0]  tick_count_next
);
  import cscg_pkg::*;

  localparam logic [32:0] CNT_MAX = (33'd1 << COUNT_WIDTH) - 33'd1;

  function automatic logic [COUNT_WIDTH-1:0] count_load(logic [CFG_WIDTH-1:0] v);
    logic [32:0] w;
    w = 33'(v);
    if (w > CNT_MAX) return '1;
    return COUNT_WIDTH'(w);
  endfunction

  logic  tc_zero;
  logic  tc_one;
  logic  fd_nz;
  ctrl_t rest_end;
  upd_t  u;
  upd_t  thaw_u;

  assign tc_zero = (tick_count == '0);
  assign tc_one  = (tick_count == COUNT_WIDTH'(1));
  assign fd_nz   = (cfg.freeze_delay != '0);

  always_comb begin
    rest_end     = cur;
    rest_end.fan = 1'b0;
    thaw_u       = begin_thaw(cur, cool, freeze, fd_nz);
  end

  always_comb begin
    unique case (cur.phase)
      PH_BOOT: begin
        if (cool) begin
          u.ctrl            = cur;
          u.op              = TC_LOAD_OFF;
          u.ctrl.phase      = PH_REST;
          u.ctrl.compressor = 1'b0;
          u.ctrl.fan        = 1'b1;
          u.ctrl.led        = 1'b1;
        end else begin
          u = evaluate(cur, 1'b0, cool, freeze, fd_nz);
        end
      end
      PH_COOL: u = evaluate(cur, 1'b1, cool, freeze, fd_nz);
      PH_START: begin
        if (tc_zero) u = evaluate(cur, 1'b1, cool, freeze, fd_nz);
        else u = '{ctrl: cur, op: TC_DEC};
      end
      PH_REST: begin
        if (tc_zero) u = evaluate(rest_end, 1'b0, cool, freeze, fd_nz);
        else u = '{ctrl: cur, op: TC_DEC};
      end
      PH_FDELAY: begin
        if (cool != cur.call_at_freeze) begin
          u = thaw_u;
        end else if (tc_zero || tc_one) begin
          u = thaw_u;
          if (u.op == TC_HOLD) u.op = tc_zero ? TC_HOLD : TC_DEC;
        end else begin
          u = '{ctrl: cur, op: TC_DEC};
        end
      end
      PH_THAW: begin
        if (!freeze) u = evaluate(cur, 1'b0, cool, 1'b0, fd_nz);
        else u = '{ctrl: cur, op: TC_HOLD};
      end
      PH_IDLE: u = evaluate(cur, 1'b0, cool, freeze, fd_nz);
      default: u = evaluate(cur, 1'b0, cool, freeze, fd_nz);
    endcase
  end

  assign ctrl_next = u.ctrl;

  always_comb begin
    unique case (u.op)
      TC_DEC:      tick_count_next = tick_count - COUNT_WIDTH'(1);
      TC_LOAD_RUN: tick_count_next = count_load(cfg.min_run);
      TC_LOAD_OFF: tick_count_next = count_load(cfg.min_off);
      TC_LOAD_FRZ: tick_count_next = count_load(cfg.freeze_delay);
      default:     tick_count_next = tick_count;
    endcase
  end

endmodule

### sv/compressor_short_cycle_guard.sv
// channel   dir  handshake      payload
// tick      in   valid/ready    cool_request, freeze_alarm
// result    out  valid/ready    compressor_on, fan_on, busy_led, phase
// apb       in   psel/penable   min_run, min_off, freeze_delay registers
//
// one tick per cycle sustained while result.ready is high; path is input register, then result register
// the phase/counter update sits between the input register and the result register
// rst is synchronous: boot phase, counter zero, drives off, registers to defaults
// a stalled result holds the pipeline; tick.ready follows result.ready when both stages are full
// depends on cscg_pkg, cscg_ifs, cscg_regs, cscg_step and the defines header
module compressor_short_cycle_guard #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  cscg_tick_if.sink                           tick,
  cscg_result_if.source                       result,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cscg_pkg::APB_ADDR_WIDTH-1:0] paddr,
  input  logic [cscg_pkg::APB_DATA_WIDTH-1:0] pwdata,
  output logic [cscg_pkg::APB_DATA_WIDTH-1:0] prdata,
  output logic                                pready
);
  import cscg_pkg::*;
  `include "compressor_short_cycle_guard_defines.svh"

  cfg_t                   cfg;
  ctrl_t                  ctrl;
  ctrl_t                  ctrl_next;
  logic [COUNT_WIDTH-1:0] tick_count;
  logic [COUNT_WIDTH-1:0] tick_count_next;
  logic                   in_valid;
  logic                   in_cool;
  logic                   in_freeze;
  logic                   out_valid;
  logic                   advance;
  logic                   step_en;
  logic                   locked_phase;

  cscg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cscg_step #(.COUNT_WIDTH(COUNT_WIDTH)) u_step (
    .cfg             (cfg),
    .cur             (ctrl),
    .tick_count      (tick_count),
    .cool            (in_cool),
    .freeze          (in_freeze),
    .ctrl_next       (ctrl_next),
    .tick_count_next (tick_count_next)
  );

  assign advance    = !out_valid || result.ready;
  assign step_en    = in_valid && advance;
  assign tick.ready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (tick.ready) begin
      in_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.ready && tick.valid) begin
      in_cool   <= tick.cool_request;
      in_freeze <= tick.freeze_alarm;
    end
  end

  // guard state
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl       <= '{phase: PH_BOOT, default: 1'b0};
      tick_count <= '0;
    end else if (step_en) begin
      ctrl       <= ctrl_next;
      tick_count <= tick_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      result.compressor_on <= ctrl_next.compressor;
      result.fan_on        <= ctrl_next.fan;
      result.busy_led      <= ctrl_next.led;
      result.phase         <= 3'(ctrl_next.phase);
    end
  end

  assign result.valid = out_valid;

  assign locked_phase = (ctrl.phase == PH_START) || (ctrl.phase == PH_REST) ||
                        (ctrl.phase == PH_FDELAY) || (ctrl.phase == PH_THAW);

  `CSCG_ASSERT_IMP(a_comp_needs_fan, ctrl.compressor, ctrl.fan, "compressor on without fan")
  `CSCG_ASSERT_IMP(a_led_locked, locked_phase, ctrl.led, "busy lamp off in a locked phase")
  `CSCG_ASSERT_NXT(a_state_hold, !step_en, $stable(ctrl) && $stable(tick_count),
                   "state moved without a beat")
  `CSCG_ASSERT_NXT(a_result_tracks, step_en, out_valid && result.phase == 3'(ctrl.phase),
                   "result phase differs from state")

endmodule
